### rtl/core/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants of the WebSocket frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package wsd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned OPCODE_W = 4;
  localparam int unsigned KEY_W    = 32;

  // One classified result on its way from the header parser to the output.
  typedef struct packed {
    logic [BYTE_W-1:0]   raw_byte;
    logic [BYTE_W-1:0]   key_byte;
    logic [OPCODE_W-1:0] opcode;
    logic                fin;
    logic                has_data;
    logic                frame_end;
  } entry_t;

endpackage

`default_nettype wire

### rtl/core/wsd_front.sv
// ----------------------------------------------------------------------------
// wsd_front
// Header parser: tracks the frame phase and turns payload bytes and empty
// frames into queue entries.
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_front #(
  parameter int unsigned LENGTH_WIDTH = 64
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [7:0]      in_byte,
  input  wire logic            q_ready,
  output logic                 q_push,
  output wsd_pkg::entry_t      q_entry
);
  import wsd_pkg::*;

  localparam logic [2:0] PH_HDR0 = 3'd0;
  localparam logic [2:0] PH_HDR1 = 3'd1;
  localparam logic [2:0] PH_EXT  = 3'd2;
  localparam logic [2:0] PH_KEY  = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  logic [2:0]              phase_r, phase_nxt;
  logic                    fin_r, fin_nxt;
  logic [OPCODE_W-1:0]     opcode_r, opcode_nxt;
  logic                    mask_r, mask_nxt;
  logic [2:0]              ext_cnt_r, ext_cnt_nxt;
  logic [LENGTH_WIDTH-1:0] rem_r, rem_nxt;
  logic [KEY_W-1:0]        key_r, key_nxt;
  logic [1:0]              kidx_r, kidx_nxt;

  logic                    accept;
  logic                    has_result;
  logic [LENGTH_WIDTH-1:0] rem_shift;
  logic [BYTE_W-1:0]       kb;
  logic                    last_byte;

  assign in_ready  = q_ready;
  assign accept    = in_valid && in_ready;
  assign q_push    = accept && has_result;
  assign rem_shift = {rem_r[LENGTH_WIDTH-9:0], in_byte};
  assign last_byte = (rem_r == LENGTH_WIDTH'(1));

  always_comb begin
    unique case (kidx_r)
      2'd0:    kb = key_r[31:24];
      2'd1:    kb = key_r[23:16];
      2'd2:    kb = key_r[15:8];
      default: kb = key_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt   = phase_r;
    fin_nxt     = fin_r;
    opcode_nxt  = opcode_r;
    mask_nxt    = mask_r;
    ext_cnt_nxt = ext_cnt_r;
    rem_nxt     = rem_r;
    key_nxt     = key_r;
    kidx_nxt    = kidx_r;
    has_result  = 1'b0;
    q_entry.raw_byte  = '0;
    q_entry.key_byte  = '0;
    q_entry.opcode    = opcode_r;
    q_entry.fin       = fin_r;
    q_entry.has_data  = 1'b0;
    q_entry.frame_end = 1'b1;

    unique case (phase_r)
      PH_HDR1: begin
        mask_nxt = in_byte[7];
        rem_nxt  = '0;
        if (in_byte[6:0] == LEN_EXT16) begin
          ext_cnt_nxt = 3'd1;
          phase_nxt   = PH_EXT;
        end else if (in_byte[6:0] == LEN_EXT64) begin
          ext_cnt_nxt = 3'd7;
          phase_nxt   = PH_EXT;
        end else begin
          rem_nxt  = LENGTH_WIDTH'(in_byte[6:0]);
          kidx_nxt = 2'd0;
          if (in_byte[7]) begin
            phase_nxt = PH_KEY;
          end else if (in_byte[6:0] == 7'd0) begin
            has_result = 1'b1;
            phase_nxt  = PH_HDR0;
          end else begin
            phase_nxt = PH_DATA;
          end
        end
      end
      PH_EXT: begin
        rem_nxt = rem_shift;
        if (ext_cnt_r == 3'd0) begin
          kidx_nxt = 2'd0;
          if (mask_r) begin
            phase_nxt = PH_KEY;
          end else if (rem_shift == '0) begin
            has_result = 1'b1;
            phase_nxt  = PH_HDR0;
          end else begin
            phase_nxt = PH_DATA;
          end
        end else begin
          ext_cnt_nxt = ext_cnt_r - 3'd1;
        end
      end
      PH_KEY: begin
        key_nxt  = {key_r[23:0], in_byte};
        kidx_nxt = kidx_r + 2'd1;
        if (kidx_r == 2'd3) begin
          kidx_nxt = 2'd0;
          if (rem_r == '0) begin
            has_result = 1'b1;
            phase_nxt  = PH_HDR0;
          end else begin
            phase_nxt = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        kidx_nxt   = kidx_r + 2'd1;
        rem_nxt    = rem_r - LENGTH_WIDTH'(1);
        has_result = 1'b1;
        q_entry.raw_byte  = in_byte;
        q_entry.key_byte  = mask_r ? kb : '0;
        q_entry.has_data  = 1'b1;
        q_entry.frame_end = last_byte;
        if (last_byte) begin
          phase_nxt = PH_HDR0;
        end
      end
      default: begin
        // First header byte; unused phase codes land here as well.
        fin_nxt    = in_byte[7];
        opcode_nxt = in_byte[3:0];
        phase_nxt  = PH_HDR1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HDR0;
      fin_r     <= 1'b0;
      opcode_r  <= '0;
      mask_r    <= 1'b0;
      ext_cnt_r <= '0;
      rem_r     <= '0;
      key_r     <= '0;
      kidx_r    <= '0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      fin_r     <= fin_nxt;
      opcode_r  <= opcode_nxt;
      mask_r    <= mask_nxt;
      ext_cnt_r <= ext_cnt_nxt;
      rem_r     <= rem_nxt;
      key_r     <= key_nxt;
      kidx_r    <= kidx_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/wsd_queue.sv
// ----------------------------------------------------------------------------
// wsd_queue
// Two-entry queue between the header parser and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire wsd_pkg::entry_t push_entry,
  output logic                 push_ready,
  input  wire logic            pop,
  output logic                 pop_valid,
  output wsd_pkg::entry_t      pop_entry
);
  import wsd_pkg::*;

  entry_t     slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_entry  = slot_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

### rtl/core/wsd_back.sv
// ----------------------------------------------------------------------------
// wsd_back
// Output stage: unmasks the payload byte and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_valid,
  input  wire wsd_pkg::entry_t q_entry,
  output logic                 q_pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [7:0]           out_data_byte,
  output logic [3:0]           out_frame_opcode,
  output logic                 out_final_fragment,
  output logic                 out_has_data,
  output logic                 out_frame_end
);
  import wsd_pkg::*;

  logic                valid_r, valid_nxt;
  logic [BYTE_W-1:0]   data_r;
  logic [OPCODE_W-1:0] opcode_r;
  logic                fin_r, has_r, end_r;

  // The register is free when it is empty or its transaction completes now.
  assign q_pop = q_valid && (!valid_r || out_ready);

  always_comb begin
    valid_nxt = valid_r;
    if (q_pop) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      data_r   <= q_entry.raw_byte ^ q_entry.key_byte;
      opcode_r <= q_entry.opcode;
      fin_r    <= q_entry.fin;
      has_r    <= q_entry.has_data;
      end_r    <= q_entry.frame_end;
    end
  end

  assign out_valid          = valid_r;
  assign out_data_byte      = data_r;
  assign out_frame_opcode   = opcode_r;
  assign out_final_fragment = fin_r;
  assign out_has_data       = has_r;
  assign out_frame_end      = end_r;

endmodule

`default_nettype wire

### rtl/core/websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Parses a WebSocket byte stream and emits unmasked payload bytes with the
// FIN bit and opcode of their frame.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake             Payload
//   in        in_valid / in_ready   in_byte[7:0]
//   out       out_valid / out_ready out_data_byte, out_frame_opcode,
//                                   out_final_fragment, out_has_data,
//                                   out_frame_end
//
// One byte is accepted per cycle while in_ready is high; its result is
// registered first in the queue and then in the output register.
// Synchronous active-low reset returns the parser to the first header byte
// and empties the queue and the output register.
// A stalled output fills the two-entry queue; in_ready drops only when it is
// full, so header bytes and payload keep flowing while the result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module websocket_frame_deframer #(
  parameter int unsigned LENGTH_WIDTH = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_data_byte,
  output logic [3:0]      out_frame_opcode,
  output logic            out_final_fragment,
  output logic            out_has_data,
  output logic            out_frame_end
);
  import wsd_pkg::*;

  logic   q_push, q_ready, q_valid, q_pop;
  entry_t push_entry, pop_entry;

  wsd_front #(
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .q_ready  (q_ready),
    .q_push   (q_push),
    .q_entry  (push_entry)
  );

  wsd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_entry  (pop_entry)
  );

  wsd_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_entry            (pop_entry),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_data_byte      (out_data_byte),
    .out_frame_opcode   (out_frame_opcode),
    .out_final_fragment (out_final_fragment),
    .out_has_data       (out_has_data),
    .out_frame_end      (out_frame_end)
  );

endmodule

`default_nettype wire

### test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for websocket_frame_deframer. Frames are built byte by
// byte (short, 16-bit and 64-bit length forms, masked and unmasked). Every
// accepted byte runs through a local model of the header parser. The model
// queues each expected result, and each result that leaves the block
// is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------

module testbench;

  import wsd_pkg::*;

  localparam int unsigned LEN_W          = 64;
  localparam int unsigned WATCHDOG_LIMIT = 200;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned RANDOM_BYTES   = 650;

  // Length codes of the second header byte that announce an extended length.
  localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
  localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

  typedef enum logic [2:0] {
    PH_HEADER0, PH_HEADER1, PH_EXT_LEN, PH_MASK_KEY, PH_PAYLOAD
  } parse_phase_e;

  typedef enum logic [1:0] {FORM_SHORT, FORM_EXT16, FORM_EXT64} len_form_e;

  typedef struct packed {
    logic [BYTE_W-1:0]   data;
    logic [OPCODE_W-1:0] opcode;
    logic                fin;
    logic                has_data;
    logic                frame_end;
  } deframed_t;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [BYTE_W-1:0]   in_byte = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [BYTE_W-1:0]   out_data_byte;
  logic [OPCODE_W-1:0] out_frame_opcode;
  logic                out_final_fragment;
  logic                out_has_data;
  logic                out_frame_end;

  // Local copy of the parser state.
  parse_phase_e       p_phase    = PH_HEADER0;
  logic               p_fin      = 1'b0;
  logic [3:0]         p_opcode   = '0;
  logic               p_masked   = 1'b0;
  logic [2:0]         p_ext_left = '0;
  logic [LEN_W-1:0]   p_remaining = '0;
  logic [KEY_W-1:0]   p_key      = '0;
  logic [1:0]         p_key_idx  = '0;

  deframed_t   pending_results[$];
  int unsigned error_count  = 0;
  int unsigned bytes_sent   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_left   = 0;
  bit          send_gaps    = 1'b0;
  bit          sink_stalls  = 1'b0;

  websocket_frame_deframer #(.LENGTH_WIDTH(LEN_W)) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_byte            (in_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_data_byte      (out_data_byte),
    .out_frame_opcode   (out_frame_opcode),
    .out_final_fragment (out_final_fragment),
    .out_has_data       (out_has_data),
    .out_frame_end      (out_frame_end)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // ---------------------------------------------------------------- model

  // The header is complete. A zero length gives the empty-frame result at once.
  function automatic bit header_complete(output deframed_t r);
    r = '0;
    p_key_idx = '0;
    if (p_remaining == '0) begin
      p_phase = PH_HEADER0;
      r = '{data: '0, opcode: p_opcode, fin: p_fin, has_data: 1'b0, frame_end: 1'b1};
      return 1'b1;
    end
    p_phase = PH_PAYLOAD;
    return 1'b0;
  endfunction

  function automatic bit length_complete(output deframed_t r);
    r = '0;
    if (p_masked) begin
      p_key_idx = '0;
      p_phase = PH_MASK_KEY;
      return 1'b0;
    end
    return header_complete(r);
  endfunction

  function automatic bit deframe_byte(input logic [BYTE_W-1:0] b, output deframed_t r);
    logic [7:0] key_byte;
    int         kidx;
    r = '0;
    deframe_byte = 1'b0;
    case (p_phase)
      PH_HEADER1: begin
        p_masked = b[7];
        p_remaining = '0;
        if (b[6:0] == LEN_CODE_EXT16) begin
          p_ext_left = 3'd1;
          p_phase = PH_EXT_LEN;
        end else if (b[6:0] == LEN_CODE_EXT64) begin
          p_ext_left = 3'd7;
          p_phase = PH_EXT_LEN;
        end else begin
          p_remaining = LEN_W'(b[6:0]);
          deframe_byte = length_complete(r);
        end
      end
      PH_EXT_LEN: begin
        p_remaining = (p_remaining << 8) | LEN_W'(b);
        if (p_ext_left == 3'd0) begin
          deframe_byte = length_complete(r);
        end else begin
          p_ext_left = p_ext_left - 3'd1;
        end
      end
      PH_MASK_KEY: begin
        p_key = {p_key[23:0], b};
        p_key_idx = p_key_idx + 2'd1;
        if (p_key_idx == 2'd0) begin
          deframe_byte = header_complete(r);
        end
      end
      PH_PAYLOAD: begin
        kidx = int'(p_key_idx);
        key_byte = p_masked ? p_key[8*(3-kidx) +: 8] : 8'h00;
        p_key_idx = p_key_idx + 2'd1;
        p_remaining = p_remaining - LEN_W'(1);
        r = '{data: b ^ key_byte, opcode: p_opcode, fin: p_fin, has_data: 1'b1,
              frame_end: (p_remaining == '0)};
        if (p_remaining == '0) begin
          p_phase = PH_HEADER0;
        end
        deframe_byte = 1'b1;
      end
      default: begin
        p_fin = b[7];
        p_opcode = b[3:0];
        p_phase = PH_HEADER1;
      end
    endcase
  endfunction

  // -------------------------------------------------------------- checking

  function automatic void check_field(input string field, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t ns: %s expected 0x%0h, actual 0x%0h", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin : monitor
    deframed_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        if (deframe_byte(in_byte, want)) begin
          pending_results.push_back(want);
        end
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          error_count++;
          $display("%0t ns: unexpected result, expected none, actual data 0x%0h",
                   $time, out_data_byte);
        end else begin
          want = pending_results.pop_front();
          check_field("out_data_byte", want.data, out_data_byte);
          check_field("out_frame_opcode", 8'(want.opcode), 8'(out_frame_opcode));
          check_field("out_final_fragment", 8'(want.fin), 8'(out_final_fragment));
          check_field("out_has_data", 8'(want.has_data), 8'(out_has_data));
          check_field("out_frame_end", 8'(want.frame_end), 8'(out_frame_end));
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("== FAIL ==");
          $finish;
        end
      end
    end
  end

  // Result side: random stall bursts while enabled.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n;
    end
  end

  // -------------------------------------------------------------- stimulus

  // Valid stays high between back-to-back bytes; it drops only for a gap.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int unsigned gap;
    if (send_gaps && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 4);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] first_byte, input logic masked,
                            input logic [63:0] len, input len_form_e form,
                            input int unsigned body_bytes);
    logic [31:0] key;
    key = $urandom;
    send_byte(first_byte);
    case (form)
      FORM_EXT16: begin
        send_byte({masked, LEN_CODE_EXT16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      FORM_EXT64: begin
        send_byte({masked, LEN_CODE_EXT64});
        for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
      end
      default: send_byte({masked, len[6:0]});
    endcase
    if (masked) begin
      for (int i = 3; i >= 0; i--) send_byte(key[8*i +: 8]);
    end
    for (int unsigned n = 0; n < body_bytes; n++) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic wait_drained;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic pause_until_drained;
    @(negedge clk);
    in_valid <= 1'b0;
    wait_drained();
  endtask

  // ----------------------------------------------------------------- tests

  // Empty frames (short, extended, and masked with a key), a masked frame
  // long enough for the key index to wrap, and the 64-bit length form.
  task automatic test_directed_frames;
    send_gaps = 1'b1;
    sink_stalls = 1'b1;
    send_frame(8'h89, 1'b0, 64'd0, FORM_SHORT, 0);
    send_frame(8'h01, 1'b1, 64'd5, FORM_SHORT, 5);
    send_frame(8'h8A, 1'b1, 64'd0, FORM_SHORT, 0);
    send_frame(8'hF0, 1'b0, 64'd0, FORM_EXT16, 0);
    send_frame(8'h0F, 1'b0, 64'd1, FORM_EXT64, 1);
  endtask

  // Random headers with all opcodes and reserved bits, mostly short payloads,
  // now and then a full short-form frame or a non-minimal extended length.
  task automatic test_random_frames;
    logic [7:0]   first_byte;
    logic         masked;
    logic [63:0]  len;
    len_form_e    form;
    int unsigned  frames;
    int unsigned  pick;
    frames = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      first_byte = 8'($urandom_range(0, 255));
      masked = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 11);
      form = FORM_SHORT;
      if (pick < 7) begin
        len = 64'($urandom_range(0, 12));
      end else if (pick == 7) begin
        len = 64'd125;
      end else if (pick == 8) begin
        len = 64'($urandom_range(0, 125));
      end else if (pick == 9) begin
        len = 64'($urandom_range(0, 300));
        form = FORM_EXT16;
      end else begin
        len = 64'($urandom_range(0, 20));
        form = FORM_EXT64;
      end
      // Some frames run with no idling at all on either side.
      send_gaps = ($urandom_range(0, 3) != 0);
      sink_stalls = ($urandom_range(0, 3) != 0);
      send_frame(first_byte, masked, len, form, 32'(len));
      if (frames == 0 || $urandom_range(0, 11) == 0) begin
        pause_until_drained();
      end
      frames++;
    end
  endtask

  task automatic test_back_to_back;
    logic [63:0] len;
    send_gaps = 1'b0;
    sink_stalls = 1'b0;
    repeat (6) begin
      len = 64'($urandom_range(0, 9));
      send_frame(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                 len, FORM_SHORT, 32'(len));
    end
  endtask

  // A 64-bit length with its top bit set is taken as given, so the frame
  // stays open for the rest of the run and no result marks its end.
  task automatic test_oversized_length;
    send_gaps = 1'b0;
    sink_stalls = 1'b0;
    send_frame(8'h82, 1'b1, 64'h8000_0000_0000_0010, FORM_EXT64, 24);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed_frames();
    test_random_frames();
    test_back_to_back();
    test_oversized_length();
    @(negedge clk);
    in_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/wsd_pkg.sv
rtl/core/wsd_front.sv
rtl/core/wsd_queue.sv
rtl/core/wsd_back.sv
rtl/core/websocket_frame_deframer.sv
test/testbench.sv
